FILE: sv/piqd_pkg.sv
// ----------------------------------------------------------------------------
// piqd_pkg
// shared types, event codes and the quadrature lookup for the panel decoder
// ----------------------------------------------------------------------------
package piqd_pkg;

  typedef enum logic [2:0] {
    EV_DONE_ON       = 3'd0,
    EV_DONE_OFF      = 3'd1,
    EV_HELP_ON       = 3'd2,
    EV_HELP_OFF      = 3'd3,
    EV_ADJUST_ENTER  = 3'd4,
    EV_REQUEST_SENT  = 3'd5,
    EV_VALUE_CHANGED = 3'd6
  } event_code_t;

  typedef enum logic [0:0] {
    REG_DETENT_STEPS = 1'b0,
    REG_VALUE_MAX    = 1'b1
  } reg_index_t;

  typedef struct packed {
    event_code_t  code;
    logic [6:0]   value;
    logic [13:0]  id;
  } result_t;

  localparam int unsigned MaxResults = 4;
  localparam logic [13:0] MSG_ID_MAX = 14'd9999;
  localparam logic [2:0]  DETENT_STEPS_RESET = 3'd4;
  localparam logic [6:0]  VALUE_MAX_RESET = 7'd99;

  // indexed by {last_phase, new_phase}
  localparam logic signed [1:0] QUAD_TABLE [16] = '{
     2'sd0, -2'sd1,  2'sd1,  2'sd0,
     2'sd1,  2'sd0,  2'sd0, -2'sd1,
    -2'sd1,  2'sd0,  2'sd0,  2'sd1,
     2'sd0,  2'sd1, -2'sd1,  2'sd0
  };

  // pre-increment id counter, wraps from the top back to one
  function automatic logic [13:0] next_id(input logic [13:0] c);
    next_id = (c >= MSG_ID_MAX) ? 14'd1 : c + 14'd1;
  endfunction

endpackage

FILE: sv/panel_input_quadrature_decoder.sv
// ----------------------------------------------------------------------------
// panel_input_quadrature_decoder
// button, push switch and quadrature encoder decoder for a control panel
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid / in_stall) carries one sample of the five
//   active-low pins. output channel (out_valid / out_stall) carries events,
//   zero to four per sample, in the order done, help, switch, encoder; the
//   last event of a sample has last set. a sample that causes no event
//   produces nothing on the output.
//   the sample is taken into an input register, then decoded in one pass
//   into a four-slot result register; state is updated on that move.
//   the first event of a sample is valid once the sample has moved into the result
//   register. throughput: one sample per cycle while samples give at most one event
//   and out_stall is low; a sample with more events holds the result register
//   while the output port drains its events, one a cycle while out_stall is low.
//   the input register takes a new sample while results still wait, so a
//   stall on the output backs up into in_stall only once both registers
//   are full. output payload holds while out_stall is high.
//   reset (synchronous, rst high) restores button history to released,
//   clears flags, adjust mode, accumulator, value and message counter, and
//   sets detent_steps to 4 and value_max to 99.
//   registers: detent_steps at 0x0, value_max at 0x4, pready tied high. the user
//   writes them via apb only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module panel_input_quadrature_decoder
  import piqd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic        done_pin,
  input  logic        help_pin,
  input  logic        switch_pin,
  input  logic        phase_a,
  input  logic        phase_b,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  event_code,
  output logic [6:0]  value,
  output logic [13:0] message_id,
  output logic        last
);

  // configuration registers
  logic [2:0] detent_steps;
  logic [6:0] value_max;

  // decoder state
  logic        prev_done, prev_help, prev_switch;
  logic        done_flag, help_flag, adjust_active;
  logic [1:0]  last_phase;
  logic signed [3:0] step_accum;
  logic [6:0]  adjust_value;
  logic [13:0] message_counter;

  // input register
  logic       in_full;
  logic       s_done, s_help, s_switch;
  logic [1:0] s_phase;

  // result register
  result_t    bundle [MaxResults];
  logic [2:0] cnt;
  logic [1:0] rd;

  // next values from the decode pass
  logic        prev_done_next, prev_help_next, prev_switch_next;
  logic        done_flag_next, help_flag_next, adjust_active_next;
  logic [1:0]  last_phase_next;
  logic signed [3:0] step_accum_next;
  logic [6:0]  adjust_value_next;
  logic [13:0] message_counter_next;
  result_t     res [MaxResults];
  logic [2:0]  n;

  logic out_take, bundle_free, move, wr_en;

  // ---------------------------------------------------------------- apb port
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      detent_steps <= DETENT_STEPS_RESET;
      value_max    <= VALUE_MAX_RESET;
    end else if (wr_en) begin
      unique case (reg_index_t'(paddr[2]))
        REG_DETENT_STEPS: detent_steps <= pwdata[2:0];
        REG_VALUE_MAX:    value_max    <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index_t'(paddr[2]))
      REG_DETENT_STEPS: prdata = {29'd0, detent_steps};
      REG_VALUE_MAX:    prdata = {25'd0, value_max};
      default:          prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------- handshake
  assign out_valid   = (cnt != 3'd0);
  assign out_take    = out_valid && !out_stall;
  // result register frees when empty or its final event leaves this cycle
  assign bundle_free = (cnt == 3'd0) || (cnt == 3'd1 && out_take);
  assign move        = in_full && bundle_free;
  assign in_stall    = in_full && !move;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (move) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s_done   <= done_pin;
      s_help   <= help_pin;
      s_switch <= switch_pin;
      s_phase  <= {phase_a, phase_b};
    end
  end

  // ---------------------------------------------------------------- decode pass
  always_comb begin
    logic [13:0] ctr;
    logic signed [1:0] delta;
    logic signed [4:0] acc5;
    logic signed [4:0] lim5;
    logic signed [8:0] v9;
    logic signed [8:0] vmax9;

    prev_done_next       = s_done;
    prev_help_next       = s_help;
    prev_switch_next     = s_switch;
    done_flag_next       = done_flag;
    help_flag_next       = help_flag;
    adjust_active_next   = adjust_active;
    last_phase_next      = last_phase;
    step_accum_next      = step_accum;
    adjust_value_next    = adjust_value;
    n                    = 3'd0;
    ctr                  = message_counter;
    delta                = 2'sd0;
    acc5                 = 5'sd0;
    lim5                 = 5'sd0;
    v9                   = 9'sd0;
    vmax9                = 9'sd0;
    for (int i = 0; i < MaxResults; i++) begin
      res[i] = '0;
    end

    // done button falling edge
    if (prev_done && !s_done) begin
      done_flag_next   = !done_flag;
      ctr              = next_id(ctr);
      res[n[1:0]].code = done_flag_next ? EV_DONE_ON : EV_DONE_OFF;
      res[n[1:0]].id   = ctr;
      n                = n + 3'd1;
    end

    // help button falling edge
    if (prev_help && !s_help) begin
      help_flag_next   = !help_flag;
      ctr              = next_id(ctr);
      res[n[1:0]].code = help_flag_next ? EV_HELP_ON : EV_HELP_OFF;
      res[n[1:0]].id   = ctr;
      n                = n + 3'd1;
    end

    // switch enters adjust mode, or sends the value and leaves
    if (prev_switch && !s_switch) begin
      res[n[1:0]].value = adjust_value;
      if (!adjust_active) begin
        adjust_active_next = 1'b1;
        res[n[1:0]].code   = EV_ADJUST_ENTER;
      end else begin
        adjust_active_next = 1'b0;
        ctr                = next_id(ctr);
        res[n[1:0]].code   = EV_REQUEST_SENT;
        res[n[1:0]].id     = ctr;
      end
      n = n + 3'd1;
    end

    // encoder, only in adjust mode; phase history is frozen otherwise
    if (adjust_active_next && (s_phase != last_phase)) begin
      last_phase_next = s_phase;
      delta           = QUAD_TABLE[{last_phase, s_phase}];
      if (delta != 2'sd0) begin
        acc5  = {step_accum[3], step_accum} + {{3{delta[1]}}, delta};
        lim5  = {2'b00, detent_steps};
        v9    = {2'b00, adjust_value};
        vmax9 = {2'b00, value_max};
        step_accum_next = acc5[3:0];
        if (acc5 >= lim5) begin
          v9              = v9 + 9'sd1;
          step_accum_next = 4'sd0;
        end else if (acc5 <= -lim5) begin
          v9              = v9 - 9'sd1;
          step_accum_next = 4'sd0;
        end
        if (v9 < 9'sd0) begin
          v9 = 9'sd0;
        end
        if (v9 > vmax9) begin
          v9 = vmax9;
        end
        adjust_value_next = v9[6:0];
        if (v9[6:0] != adjust_value) begin
          res[n[1:0]].code  = EV_VALUE_CHANGED;
          res[n[1:0]].value = v9[6:0];
          n                 = n + 3'd1;
        end
      end
    end

    message_counter_next = ctr;
  end

  // ---------------------------------------------------------------- state update
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_done       <= 1'b1;
      prev_help       <= 1'b1;
      prev_switch     <= 1'b1;
      done_flag       <= 1'b0;
      help_flag       <= 1'b0;
      adjust_active   <= 1'b0;
      last_phase      <= 2'd0;
      step_accum      <= 4'sd0;
      adjust_value    <= 7'd0;
      message_counter <= 14'd0;
    end else if (move) begin
      prev_done       <= prev_done_next;
      prev_help       <= prev_help_next;
      prev_switch     <= prev_switch_next;
      done_flag       <= done_flag_next;
      help_flag       <= help_flag_next;
      adjust_active   <= adjust_active_next;
      last_phase      <= last_phase_next;
      step_accum      <= step_accum_next;
      adjust_value    <= adjust_value_next;
      message_counter <= message_counter_next;
    end
  end

  // ---------------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 3'd0;
      rd  <= 2'd0;
    end else if (move) begin
      cnt <= n;
      rd  <= 2'd0;
    end else if (out_take) begin
      cnt <= cnt - 3'd1;
      rd  <= rd + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      for (int i = 0; i < MaxResults; i++) begin
        bundle[i] <= res[i];
      end
    end
  end

  assign event_code = bundle[rd].code;
  assign value      = bundle[rd].value;
  assign message_id = bundle[rd].id;
  assign last       = (cnt == 3'd1);

  // ---------------------------------------------------------------- assertions
  // a stall on the input only comes from a held sample
  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_full)
    else $error("input stalled with empty input register");

  // an event without last is always followed by another one
  a_more_follow: assert property (@(posedge clk) disable iff (rst)
    (out_take && !last) |=> out_valid)
    else $error("events of a sample lost before last");

  // local events carry no message id
  a_no_id_local: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (event_code == EV_ADJUST_ENTER || event_code == EV_VALUE_CHANGED))
      |-> (message_id == 14'd0))
    else $error("local event carries a message id");

  // counter never leaves its wrapping range
  a_counter_range: assert property (@(posedge clk) disable iff (rst)
    move |=> (message_counter <= MSG_ID_MAX))
    else $error("message counter out of range");

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// panel decoder check: buttons, push switch and quadrature encoder events
//
// sends pin samples over the input channel and compares every event on the
// output channel with a predicted copy of the decoder. covers button and
// switch edges, stale encoder phase at adjust entry, detent counting at
// several detent sizes, clamping at both ends and after lowering the clamp,
// and back pressure from a long output stall
// ----------------------------------------------------------------------------
module testbench;
  import piqd_pkg::*;

  // run length guard, far above the slowest correct run
  localparam int CYCLE_LIMIT = 1000000;
  // cycles to let a sample with no events drain before a register write
  localparam int IDLE_SETTLE = 8;
  // long output hold used to back the block up into its input
  localparam int HOLD_CYCLES = 60;

  // one predicted or observed event
  typedef struct {
    event_code_t code;
    logic [6:0]  value;
    logic [13:0] id;
    logic        last;
  } panel_event_t;

  // predicted decoder state plus the queue of events still to arrive
  class panel_event_scoreboard;
    panel_event_t awaited[$];
    int           errors;
    logic [2:0]   detent_steps;
    logic [6:0]   value_max;
    logic         prev_done, prev_help, prev_switch;
    logic         done_on, help_on, adjusting;
    logic [1:0]   last_phase;
    int           step_accum;
    int           adj_value;
    logic [13:0]  msg_count;

    function new();
      errors       = 0;
      detent_steps = DETENT_STEPS_RESET;
      value_max    = VALUE_MAX_RESET;
      prev_done    = 1'b1;
      prev_help    = 1'b1;
      prev_switch  = 1'b1;
      done_on      = 1'b0;
      help_on      = 1'b0;
      adjusting    = 1'b0;
      last_phase   = 2'b00;
      step_accum   = 0;
      adj_value    = 0;
      msg_count    = '0;
    endfunction

    function void set_register(input reg_index_t idx, input logic [31:0] data);
      case (idx)
        REG_DETENT_STEPS: detent_steps = data[2:0];
        REG_VALUE_MAX:    value_max    = data[6:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // id counter advances before use and wraps from 9999 to 1
    function logic [13:0] take_id();
      msg_count = msg_count + 14'd1;
      if (msg_count > MSG_ID_MAX) msg_count = 14'd1;
      return msg_count;
    endfunction

    // signed step for a phase change {from, to}, gray code order 00 10 11 01
    function int quad_step(input logic [1:0] from, input logic [1:0] to);
      case ({from, to})
        4'b0010, 4'b0100, 4'b1011, 4'b1101: return 1;
        4'b0001, 4'b0111, 4'b1000, 4'b1110: return -1;
        default: return 0;
      endcase
    endfunction

    function void add_event(input event_code_t code, input logic [6:0] val,
                            input logic [13:0] id);
      panel_event_t e;
      e.code  = code;
      e.value = val;
      e.id    = id;
      e.last  = 1'b0;
      awaited.push_back(e);
    endfunction

    // pins are {done, help, switch, a, b}; returns the number of events
    function int note_sample(input logic [4:0] pins);
      logic [1:0] np;
      int         n0;
      int         delta;
      int         prior_value;
      int         lim;
      n0 = awaited.size();
      if (prev_done && !pins[4]) begin
        done_on = !done_on;
        add_event(done_on ? EV_DONE_ON : EV_DONE_OFF, 7'd0, take_id());
      end
      prev_done = pins[4];
      if (prev_help && !pins[3]) begin
        help_on = !help_on;
        add_event(help_on ? EV_HELP_ON : EV_HELP_OFF, 7'd0, take_id());
      end
      prev_help = pins[3];
      if (prev_switch && !pins[2]) begin
        if (!adjusting) begin
          adjusting = 1'b1;
          add_event(EV_ADJUST_ENTER, 7'(adj_value), 14'd0);
        end else begin
          add_event(EV_REQUEST_SENT, 7'(adj_value), take_id());
          adjusting = 1'b0;
        end
      end
      prev_switch = pins[2];
      // phases only tracked in adjust mode
      if (adjusting) begin
        np = pins[1:0];
        if (np != last_phase) begin
          delta = quad_step(last_phase, np);
          if (delta != 0) begin
            prior_value = adj_value;
            lim = int'(detent_steps);
            step_accum += delta;
            if (step_accum >= lim) begin
              adj_value++;
              step_accum = 0;
            end else if (step_accum <= -lim) begin
              adj_value--;
              step_accum = 0;
            end
            if (adj_value < 0) adj_value = 0;
            if (adj_value > int'(value_max)) adj_value = int'(value_max);
            if (adj_value != prior_value)
              add_event(EV_VALUE_CHANGED, 7'(adj_value), 14'd0);
          end
          last_phase = np;
        end
      end
      if (awaited.size() > n0) awaited[awaited.size() - 1].last = 1'b1;
      return awaited.size() - n0;
    endfunction

    function void check_event(input logic [2:0] code, input logic [6:0] val,
                              input logic [13:0] id, input logic lst);
      panel_event_t want;
      if (awaited.size() == 0) begin
        $error("event with none awaited: event_code %0d value %0d message_id %0d",
               code, val, id);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (code !== want.code) begin
        $error("event_code: expected %0d, actual %0d", want.code, code);
        errors++;
      end
      if (val !== want.value) begin
        $error("value: expected %0d, actual %0d", want.value, val);
        errors++;
      end
      if (id !== want.id) begin
        $error("message_id: expected %0d, actual %0d", want.id, id);
        errors++;
      end
      if (lst !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, lst);
        errors++;
      end
    endfunction
  endclass

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  // apb side
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  // sample channel, pins idle high (released)
  logic in_valid   = 1'b0;
  logic in_stall;
  logic done_pin   = 1'b1;
  logic help_pin   = 1'b1;
  logic switch_pin = 1'b1;
  logic phase_a    = 1'b0;
  logic phase_b    = 1'b0;

  // event channel
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  event_code;
  logic [6:0]  value;
  logic [13:0] message_id;
  logic        last;

  panel_event_scoreboard sb = new();

  // pacing state shared by both sides
  bit         hold_request = 1'b0;  // asks the event side for a long hold
  int         calm_left = 0;        // samples the sender offers back to back
  int         send_run_left = 0;
  bit         send_busy = 1'b0;
  int         recv_run_left = 0;
  bit         recv_busy = 1'b0;
  int         hold_left = 0;
  int         stall_left = 0;
  int         cycle_count = 0;
  int         counted_items = 0;
  logic [4:0] cur = 5'b11100;       // last pins offered

  panel_input_quadrature_decoder u_top (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .done_pin   (done_pin),
    .help_pin   (help_pin),
    .switch_pin (switch_pin),
    .phase_a    (phase_a),
    .phase_b    (phase_b),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .event_code (event_code),
    .value      (value),
    .message_id (message_id),
    .last       (last)
  );

  always #6 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $error("no progress within %0d cycles, %0d events outstanding",
             CYCLE_LIMIT, sb.pending());
      $display("testbench: done, errors");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(15, 30);
  endfunction

  // next phase pair one gray step up or down
  function automatic logic [1:0] turn(input logic [1:0] p, input bit up);
    case (p)
      2'b00:   return up ? 2'b10 : 2'b01;
      2'b10:   return up ? 2'b11 : 2'b00;
      2'b11:   return up ? 2'b01 : 2'b10;
      default: return up ? 2'b00 : 2'b11;
    endcase
  endfunction

  // event side: sample the transfer before this edge, then pick next stall
  always @(posedge clk) begin
    bit stall_now;
    if (!rst && out_valid && !out_stall)
      sb.check_event(event_code, value, message_id, last);
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    stall_now = 1'b0;
    if (hold_left > 0) begin
      hold_left--;
      stall_now = 1'b1;
    end else begin
      // alternate stretches of random stalls and stretches with none
      if (recv_run_left == 0) begin
        recv_run_left = $urandom_range(10, 50);
        recv_busy = ($urandom_range(0, 2) != 0);
      end
      recv_run_left--;
      if (stall_left == 0 && recv_busy) stall_left = pick_gap();
      if (stall_left > 0) begin
        stall_left--;
        stall_now = 1'b1;
      end
    end
    out_stall <= stall_now;
  end

  // offer one sample after an optional gap; entered and left at a rising edge
  task automatic play(input logic [4:0] p);
    int gap;
    if (send_run_left == 0) begin
      send_run_left = $urandom_range(8, 40);
      send_busy = ($urandom_range(0, 2) != 0);
    end
    send_run_left--;
    gap = 0;
    if (calm_left > 0) calm_left--;
    else if (send_busy) gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    done_pin   <= p[4];
    help_pin   <= p[3];
    switch_pin <= p[2];
    phase_a    <= p[1];
    phase_b    <= p[0];
    // transfer happens at the first edge where the block is not stalling
    do @(posedge clk); while (in_stall);
    void'(sb.note_sample(p));
    counted_items++;
    cur = p;
  endtask

  // drain everything, then leave room for samples that made no event
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  // setup then access cycle; pready is tied high so the access ends at once
  task automatic reg_write(input reg_index_t idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_register(idx, data);
  endtask

  task automatic configure(input int steps, input int vmax);
    wait_idle();
    reg_write(REG_DETENT_STEPS, 32'(steps));
    reg_write(REG_VALUE_MAX, 32'(vmax));
  endtask

  // mostly real use: taps and rotation runs in adjust mode, some noise
  task automatic random_session(input int target);
    int         start;
    int         pick;
    int         steps;
    bit         up;
    logic [2:0] mask;
    logic [4:0] p;
    start = counted_items;
    while (counted_items - start < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        // raw noise on all pins
        play(5'($urandom_range(0, 31)));
      end else if (pick < 30) begin
        // press and release any mix of the buttons and switch
        mask = 3'($urandom_range(1, 7));
        p = cur & ~{mask, 2'b00};
        if ($urandom_range(0, 99) < 40) p[1:0] = turn(p[1:0], 1'($urandom_range(0, 1)));
        play(p);
        play(cur | {mask, 2'b00});
      end else begin
        // rotation run, usually inside an adjust session
        if (!sb.adjusting && $urandom_range(0, 99) < 75) begin
          play(cur & 5'b11011);
          play(cur | 5'b00100);
        end
        up = 1'($urandom_range(0, 1));
        steps = $urandom_range(1, 12);
        repeat (steps) begin
          pick = $urandom_range(0, 99);
          p = cur;
          if (pick < 8) p[1:0] = turn(cur[1:0], !up);       // contact bounce
          else if (pick < 12) p[1:0] = cur[1:0] ^ 2'b11;    // skipped state
          else p[1:0] = turn(cur[1:0], up);
          play(p);
        end
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed, reset settings (4 steps per detent, clamp 99)
    play(5'b11110);  // encoder ignored while not adjusting
    play(5'b00110);  // both buttons at once, two fresh ids
    play(5'b11010);  // enter adjust; phase compared with the stale pair
    play(5'b11100);
    play(5'b11101);  // walk down four steps, value held at zero
    play(5'b11111);
    play(5'b11110);
    play(5'b11100);
    play(5'b01100);  // first button off
    play(5'b11100);
    play(5'b11000);  // leave adjust, request sent with id
    play(5'b11100);

    // ---- one step per detent, full clamp range
    configure(1, 127);
    play(5'b00010);  // four events: done, help, enter, value change
    play(5'b11111);
    play(5'b11100);  // skipped state, no step
    play(5'b11110);

    // value above the new clamp: next step reports the clamp
    configure(1, 1);
    play(5'b11111);
    play(5'b11101);  // held at the top, nothing reported

    // zero detent counts every step, zero clamp pins the value
    configure(0, 0);
    play(5'b11100);
    play(5'b11101);
    play(5'b11001);
    play(5'b11101);

    // ---- random sessions across settings
    configure(2, 64);
    random_session(14);

    // back pressure: long output hold while samples keep coming
    configure(1, 127);
    hold_request = 1'b1;
    calm_left = 40;
    random_session(14);

    configure(3, 20);
    random_session(14);
    configure(7, 127);
    random_session(14);
    configure(1, 5);
    random_session(14);

    configure(4, 99);
    random_session(14);

    // drain and let any late event show up
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
